// ===== hdl/trrq_pkg.sv =====
// Package for the tokened request retry queue: opcodes, event codes, sizes and FSM states.
// Used by trrq_ctrl, trrq_dp and tokened_request_retry_queue.
`timescale 1ns / 1ps
package trrq_pkg;
    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [31:0] TOKEN_STEP = 32'h9E37_79B9;

    localparam logic [1:0] OP_SELECT = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_STATE  = 2'd2;
    localparam logic [1:0] OP_ERROR  = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_COALESCED = 3'd1;
    localparam logic [2:0] EV_STALE     = 3'd2;
    localparam logic [2:0] EV_REJECTED  = 3'd3;
    localparam logic [2:0] EV_ERROR     = 3'd4;

    localparam logic [2:0] CFG_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_FRESH   = 3'd1;
    localparam logic [2:0] CFG_SEED    = 3'd2;
    localparam logic [2:0] CFG_INIT    = 3'd3;
    localparam logic [2:0] CFG_LIMIT   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic capture;  // latch the input item and read the head entry
        logic execute;  // perform the update and load the result register
    } t_cmd;
endpackage

// ===== hdl/trrq_ctrl.sv =====
// Controller state machine for the retry queue: sequences capture, execute and output.
// Depends on trrq_pkg.
`timescale 1ns / 1ps
module trrq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output trrq_pkg::t_cmd  o_cmd
);
    trrq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= trrq_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            trrq_pkg::S_IDLE: if (i_in_valid) n_state = trrq_pkg::S_READ;
            trrq_pkg::S_READ: n_state = trrq_pkg::S_EXEC;
            trrq_pkg::S_EXEC: n_state = trrq_pkg::S_OUT;
            trrq_pkg::S_OUT:  if (i_out_ready) n_state = trrq_pkg::S_IDLE;
            default:          n_state = trrq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == trrq_pkg::S_IDLE);
        o_out_valid   = (r_state == trrq_pkg::S_OUT);
        o_cmd.capture = (r_state == trrq_pkg::S_IDLE) && i_in_valid;
        o_cmd.execute = (r_state == trrq_pkg::S_EXEC);
    end
endmodule

// ===== hdl/trrq_dp.sv =====
// Datapath of the retry queue: entry memories, pointers, flags, token generator, results.
// Depends on trrq_pkg.
`timescale 1ns / 1ps
module trrq_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  trrq_pkg::t_cmd         i_cmd,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    input  logic [1:0]             i_opcode,
    input  logic                   i_connected,
    input  logic                   i_link_ready,
    input  logic [31:0]            i_now_ms,
    input  logic [7:0]             i_flavor_in,
    input  logic                   i_audible,
    input  logic [31:0]            i_token_in,
    input  logic                   i_established,
    input  logic                   i_persisted,
    input  logic                   i_persist_error,
    output logic                   o_send_valid,
    output logic [7:0]             o_send_flavor,
    output logic                   o_send_audible,
    output logic [31:0]            o_send_token,
    output logic                   o_send_retry,
    output logic                   o_apply_valid,
    output logic [7:0]             o_apply_flavor,
    output logic                   o_synchronized,
    output logic                   o_awaiting_persist,
    output logic [3:0]             o_pending_count,
    output logic [31:0]            o_ack_latency_ms,
    output logic [2:0]             o_event_code
);
    localparam int IW = trrq_pkg::IDX_W;
    localparam int CW = trrq_pkg::CNT_W;
    localparam logic [IW-1:0] LAST = IW'(trrq_pkg::QUEUE_DEPTH - 1);

    // Entry memories.
    logic [7:0]  m_flavor [trrq_pkg::QUEUE_DEPTH];
    logic        m_aud    [trrq_pkg::QUEUE_DEPTH];
    logic [31:0] m_token  [trrq_pkg::QUEUE_DEPTH];
    logic [31:0] m_qtime  [trrq_pkg::QUEUE_DEPTH];
    logic [31:0] m_first  [trrq_pkg::QUEUE_DEPTH];
    logic [31:0] m_last   [trrq_pkg::QUEUE_DEPTH];
    logic        m_sent   [trrq_pkg::QUEUE_DEPTH];

    // Configuration.
    logic [15:0] r_timeout, r_fresh;
    logic [7:0]  r_init, r_limit;

    // Control state.
    logic [IW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    logic [31:0]   r_tokgen;
    logic [7:0]    r_desired, r_partner;
    logic          r_sync, r_offline, r_ppend, r_ppers, r_perr;

    // Captured item and head read data.
    logic [1:0]  r_op;
    logic        r_conn, r_rdy, r_aud_in, r_est, r_pers, r_perr_in;
    logic [31:0] r_now, r_tok_in;
    logic [7:0]  r_fl_in;
    logic [7:0]  r_h_flavor;
    logic        r_h_aud, r_h_sent;
    logic [31:0] r_h_token, r_h_qtime, r_h_first, r_h_last;

    // Result register.
    logic        r_sv, r_sa, r_sr, r_av;
    logic [7:0]  r_sf, r_af;
    logic [31:0] r_st, r_lat;
    logic [2:0]  r_ev;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_opcode;
            r_conn    <= i_connected;
            r_rdy     <= i_link_ready;
            r_now     <= i_now_ms;
            r_fl_in   <= i_flavor_in;
            r_aud_in  <= i_audible;
            r_tok_in  <= i_token_in;
            r_est     <= i_established;
            r_pers    <= i_persisted;
            r_perr_in <= i_persist_error;
            r_h_flavor <= m_flavor[r_head];
            r_h_aud    <= m_aud[r_head];
            r_h_sent   <= m_sent[r_head];
            r_h_token  <= m_token[r_head];
            r_h_qtime  <= m_qtime[r_head];
            r_h_first  <= m_first[r_head];
            r_h_last   <= m_last[r_head];
        end
    end

    // Execute-stage combinational decisions.
    logic          w_bad, w_empty, w_full, w_wait, w_stale_aud, w_do_tick;
    logic          w_match, w_can_adopt;
    logic [IW-1:0] w_slot, w_head_nx, w_tail_nx;
    logic [31:0]   w_tok_sum, w_tok_new, w_lat;
    logic [7:0]    w_init_ok;

    always_comb begin
        w_bad      = r_fl_in > r_limit;
        w_empty    = (r_count == '0);
        w_full     = (r_count >= CW'(trrq_pkg::QUEUE_DEPTH));
        w_slot     = (r_tail == '0) ? LAST : r_tail - 1'b1;
        w_tail_nx  = (r_tail == LAST) ? '0 : r_tail + 1'b1;
        w_head_nx  = (r_head == LAST) ? '0 : r_head + 1'b1;
        w_tok_sum  = r_tokgen + trrq_pkg::TOKEN_STEP;
        w_tok_new  = (w_tok_sum == '0) ? 32'd1 : w_tok_sum;
        w_wait     = r_h_sent && ((r_now - r_h_last) < {16'd0, r_timeout});
        w_stale_aud = r_h_aud && ((r_now - r_h_qtime) > {16'd0, r_fresh});
        w_do_tick  = !w_empty && r_conn && !w_wait;
        w_match    = !w_empty && (r_h_token == r_tok_in);
        w_lat      = r_now - r_h_first;
        // Queue empty after a matching pop when only one entry was held.
        w_can_adopt = !r_offline &&
                      (w_empty || (w_match && r_tok_in != '0 && r_count == CW'(1)));
        w_init_ok  = (i_cfg_data[7:0] <= r_limit) ? i_cfg_data[7:0] : 8'd0;
    end

    // Memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            if (r_op == trrq_pkg::OP_SELECT && !w_bad && r_conn) begin
                m_flavor[w_full ? w_slot : r_tail] <= r_fl_in;
                m_aud[w_full ? w_slot : r_tail]    <= r_aud_in;
                m_token[w_full ? w_slot : r_tail]  <= w_tok_new;
                m_qtime[w_full ? w_slot : r_tail]  <= r_now;
                m_first[w_full ? w_slot : r_tail]  <= '0;
                m_last[w_full ? w_slot : r_tail]   <= '0;
                m_sent[w_full ? w_slot : r_tail]   <= 1'b0;
            end else if (r_op == trrq_pkg::OP_TICK && w_do_tick) begin
                if (w_stale_aud) m_aud[r_head] <= 1'b0;
                if (r_rdy) begin
                    if (!r_h_sent) m_first[r_head] <= r_now;
                    m_last[r_head] <= r_now;
                    m_sent[r_head] <= 1'b1;
                end
            end
        end
    end

    // Control state and results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd750;
            r_fresh   <= 16'd300;
            r_init    <= 8'd0;
            r_limit   <= 8'd1;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_tokgen  <= 32'd1;
            r_desired <= 8'd0;
            r_partner <= 8'd0;
            r_sync    <= 1'b0;
            r_offline <= 1'b0;
            r_ppend   <= 1'b0;
            r_ppers   <= 1'b0;
            r_perr    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                trrq_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                trrq_pkg::CFG_FRESH:   r_fresh <= i_cfg_data[15:0];
                trrq_pkg::CFG_SEED:    r_tokgen <= (i_cfg_data == '0) ? 32'd1 : i_cfg_data;
                trrq_pkg::CFG_INIT: begin
                    r_init    <= i_cfg_data[7:0];
                    r_desired <= w_init_ok;
                    r_partner <= w_init_ok;
                end
                trrq_pkg::CFG_LIMIT:   r_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end else if (i_cmd.execute) begin
            case (r_op)
                trrq_pkg::OP_SELECT: begin
                    if (!w_bad) begin
                        r_desired <= r_fl_in;
                        r_sync    <= 1'b0;
                        r_ppend   <= 1'b1;
                        if (!r_conn) begin
                            r_head    <= '0;
                            r_tail    <= '0;
                            r_count   <= '0;
                            r_offline <= 1'b1;
                        end else begin
                            r_tokgen <= w_tok_new;
                            if (!w_full) begin
                                r_tail  <= w_tail_nx;
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end
                end
                trrq_pkg::OP_TICK: ;
                trrq_pkg::OP_STATE: begin
                    if (!w_bad) begin
                        r_partner <= r_fl_in;
                        r_ppers   <= r_pers;
                        r_perr    <= r_perr_in;
                        if (r_tok_in != '0 && w_match) begin
                            r_head  <= w_head_nx;
                            r_count <= r_count - 1'b1;
                        end
                        if (w_can_adopt) begin
                            r_desired <= r_fl_in;
                            r_sync    <= r_est;
                            r_ppend   <= !r_pers;
                        end
                    end
                end
                default: begin
                    if (!w_empty) begin
                        r_head  <= w_head_nx;
                        r_count <= r_count - 1'b1;
                    end
                    r_sync <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_sv  <= 1'b0;
            r_sf  <= '0;
            r_sa  <= 1'b0;
            r_st  <= '0;
            r_sr  <= 1'b0;
            r_av  <= 1'b0;
            r_af  <= '0;
            r_lat <= '0;
            r_ev  <= trrq_pkg::EV_NONE;
            case (r_op)
                trrq_pkg::OP_SELECT: begin
                    if (w_bad) r_ev <= trrq_pkg::EV_REJECTED;
                    else if (r_conn && w_full) r_ev <= trrq_pkg::EV_COALESCED;
                end
                trrq_pkg::OP_TICK: begin
                    if (w_do_tick && r_rdy) begin
                        r_sv <= 1'b1;
                        r_sf <= r_h_flavor;
                        r_sa <= r_h_aud && !w_stale_aud;
                        r_st <= r_h_token;
                        r_sr <= r_h_sent;
                    end
                end
                trrq_pkg::OP_STATE: begin
                    if (w_bad) r_ev <= trrq_pkg::EV_REJECTED;
                    else begin
                        if (r_tok_in != '0 && !w_match) r_ev <= trrq_pkg::EV_STALE;
                        if (r_tok_in != '0 && w_match) r_lat <= w_lat;
                        if (w_can_adopt) begin
                            r_av <= 1'b1;
                            r_af <= r_fl_in;
                        end
                    end
                end
                default: r_ev <= trrq_pkg::EV_ERROR;
            endcase
        end
    end

    always_comb begin
        o_send_valid       = r_sv;
        o_send_flavor      = r_sf;
        o_send_audible     = r_sa;
        o_send_token       = r_st;
        o_send_retry       = r_sr;
        o_apply_valid      = r_av;
        o_apply_flavor     = r_af;
        o_synchronized     = r_sync;
        o_awaiting_persist = r_ppend;
        o_pending_count    = 4'(r_count) + {3'd0, r_offline};
        o_ack_latency_ms   = r_lat;
        o_event_code       = r_ev;
    end
endmodule

// ===== hdl/tokened_request_retry_queue.sv =====
// Top level of the tokened request retry queue: joins controller and datapath.
// Depends on trrq_pkg, trrq_ctrl and trrq_dp.
`timescale 1ns / 1ps
// The block queues outgoing selection requests. Each request is stamped with a nonzero token
// that advances by the golden-ratio step. On service ticks the block resends the head once the
// response timeout has passed, and it pops the head on a matching or error response. Items
// are handled one at a time. After the input transfer, an item passes through a read state
// and then an execute state, which registers its result. The result is then held until the
// output transfer completes. A new item is taken only after that, so each item passes in turn
// through the idle state that takes the input transfer, the read state, the execute state and
// the output state that presents the result.
// Configuration must be written only while the block is idle with no item in flight. The
// status outputs (synchronized, pending count, awaiting persist) show the state after the
// item whose result is presented.
module tokened_request_retry_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic        i_connected,
    input  logic        i_link_ready,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_flavor_in,
    input  logic        i_audible,
    input  logic [31:0] i_token_in,
    input  logic        i_established,
    input  logic        i_persisted,
    input  logic        i_persist_error,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_valid,
    output logic [7:0]  o_send_flavor,
    output logic        o_send_audible,
    output logic [31:0] o_send_token,
    output logic        o_send_retry,
    output logic        o_apply_valid,
    output logic [7:0]  o_apply_flavor,
    output logic        o_synchronized,
    output logic        o_awaiting_persist,
    output logic [3:0]  o_pending_count,
    output logic [31:0] o_ack_latency_ms,
    output logic [2:0]  o_event_code
);
    trrq_pkg::t_cmd w_cmd;

    // Configuration is always taken; writes must occur only while idle, which the block itself does not enforce.
    assign o_cfg_ready = 1'b1;

    trrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    trrq_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_opcode           (i_opcode),
        .i_connected        (i_connected),
        .i_link_ready       (i_link_ready),
        .i_now_ms           (i_now_ms),
        .i_flavor_in        (i_flavor_in),
        .i_audible          (i_audible),
        .i_token_in         (i_token_in),
        .i_established      (i_established),
        .i_persisted        (i_persisted),
        .i_persist_error    (i_persist_error),
        .o_send_valid       (o_send_valid),
        .o_send_flavor      (o_send_flavor),
        .o_send_audible     (o_send_audible),
        .o_send_token       (o_send_token),
        .o_send_retry       (o_send_retry),
        .o_apply_valid      (o_apply_valid),
        .o_apply_flavor     (o_apply_flavor),
        .o_synchronized     (o_synchronized),
        .o_awaiting_persist (o_awaiting_persist),
        .o_pending_count    (o_pending_count),
        .o_ack_latency_ms   (o_ack_latency_ms),
        .o_event_code       (o_event_code)
    );
endmodule
